// ----- hdl/lru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_pkg
// Shared types and constants for the LRU page replacement stack.
// ----------------------------------------------------------------------------
package lru_pkg;

    // Default sizes of the stack.
    localparam int LRU_MAX_FRAMES = 16;
    localparam int LRU_PAGE_BITS  = 16;

    // Widths of the port fields.
    localparam int PAGE_W   = 16;
    localparam int FRAMES_W = 5;
    localparam int COUNT_W  = 32;

    // Value of frames_in_use after reset.
    localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_W'(16);

    // Input beat: one page reference.
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              end_of_string;
    } t_in_beat;

    // Output beat: one result per reference.
    typedef struct packed {
        logic               hit;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] fault_count;
    } t_out_beat;

    // Per-beat command broadcast to every cell.
    typedef struct packed {
        logic load;   // a reference is accepted this cycle
        logic clear;  // empty the slot after this reference
    } t_cell_cmd;

endpackage

// ----- hdl/lru_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cell
// One slot of the LRU stack: compares its page with the search key, passes
// the "no match yet" flag on to the next slot and takes its left neighbor's
// contents when the stack shifts through it.
// ----------------------------------------------------------------------------
module lru_cell #(
    parameter int PAGE_BITS = lru_pkg::LRU_PAGE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lru_pkg::t_cell_cmd   i_cmd,
    input  logic                 i_active,
    input  logic [PAGE_BITS-1:0] i_key,
    input  logic [PAGE_BITS-1:0] i_left_page,
    input  logic                 i_left_valid,
    input  logic                 i_nomatch,
    output logic                 o_nomatch,
    output logic [PAGE_BITS-1:0] o_page,
    output logic                 o_valid
);
    import lru_pkg::*;

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic                 n_valid;
    logic                 w_match;
    logic                 w_take;

    // A slot only takes part in the search while it lies inside the active frames.
    assign w_match   = i_active && r_valid && (r_page == i_key);
    assign o_nomatch = i_nomatch && !w_match;

    // The shift reaches every active slot up to and including the first match.
    assign w_take = i_cmd.load && i_nomatch && i_active;

    // Page storage needs no reset; it is read only where the valid mark is set.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_page <= i_left_page;
        end
    end

    // Valid mark: shift first, then an end-of-string clear wins.
    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = i_left_valid;
        end
        if (i_cmd.load && i_cmd.clear) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_page  = r_page;
    assign o_valid = r_valid;

endmodule

// ----- hdl/lru_page_replacement_unit.sv -----
`timescale 1ns / 1ps
// A result beat is registered in the output register in the cycle after its reference is accepted.
// Throughput: one reference per cycle while the output is not stalled; the match flag
// ripples through all slot cells in that cycle, and that chain sets the clock period.
// A stalled output beat holds its register and blocks the input until it is taken.
// Reset (synchronous, active low) empties all slots, zeroes the fault count and
// sets frames_in_use to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// LRU page replacement stack built as a row of slot cells with a saturating
// fault counter and a registered result beat.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit #(
    parameter int MAX_FRAMES = lru_pkg::LRU_MAX_FRAMES,
    parameter int PAGE_BITS  = lru_pkg::LRU_PAGE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Reference channel.
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  lru_pkg::t_in_beat              i_in_data,
    // Result channel.
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output lru_pkg::t_out_beat             o_out_data,
    // Configuration channel: frames_in_use.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lru_pkg::FRAMES_W-1:0]   i_cfg_data
);
    import lru_pkg::*;

    localparam int CW = $clog2(MAX_FRAMES + 1);

    logic [FRAMES_W-1:0]   r_frames;
    logic [CW-1:0]         w_n;
    logic [CW-1:0]         w_bottom;
    logic                  w_accept;
    t_cell_cmd             w_cmd;
    logic [PAGE_BITS-1:0]  w_key;
    logic [MAX_FRAMES:0]   w_nomatch;
    logic [PAGE_BITS-1:0]  w_page  [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] w_valid;
    logic [MAX_FRAMES-1:0] w_active;
    logic                  w_hit;
    logic                  w_ev_valid;
    logic [PAGE_BITS-1:0]  w_ev_page;
    logic [COUNT_W-1:0]    r_faults;
    logic [COUNT_W-1:0]    w_faults_inc;
    logic [COUNT_W-1:0]    n_faults;
    logic                  r_out_valid;
    t_out_beat             r_out;

    // Configuration register; the user must write it only while the block is idle, as the block does not enforce this.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= FRAMES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frames <= i_cfg_data;
        end
    end

    // Active frame count, clamped to one at the low end and to the slot count above.
    always_comb begin
        priority if (r_frames == '0) begin
            w_n = CW'(1);
        end else if (32'(r_frames) > MAX_FRAMES) begin
            w_n = CW'(MAX_FRAMES);
        end else begin
            w_n = CW'(r_frames);
        end
    end

    assign w_bottom = w_n - CW'(1);

    // Handshake: a new beat enters while the output register is free or draining.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_cmd.load  = w_accept;
    assign w_cmd.clear = i_in_data.end_of_string;
    assign w_key       = PAGE_BITS'(i_in_data.page);

    // Slot zero is fed with the key itself; the chain starts with no match.
    assign w_nomatch[0] = 1'b1;

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        logic [PAGE_BITS-1:0] w_left_page;
        logic                 w_left_valid;

        assign w_active[g] = (CW'(g) < w_n);

        if (g == 0) begin : g_head
            assign w_left_page  = w_key;
            assign w_left_valid = 1'b1;
        end else begin : g_body
            assign w_left_page  = w_page[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        lru_cell #(
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_active     (w_active[g]),
            .i_key        (w_key),
            .i_left_page  (w_left_page),
            .i_left_valid (w_left_valid),
            .i_nomatch    (w_nomatch[g]),
            .o_nomatch    (w_nomatch[g+1]),
            .o_page       (w_page[g]),
            .o_valid      (w_valid[g])
        );
    end

    assign w_hit = !w_nomatch[MAX_FRAMES];

    // Eviction candidate: the bottom active slot, picked by an and-or select.
    always_comb begin
        w_ev_valid = 1'b0;
        w_ev_page  = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (CW'(i) == w_bottom) begin
                w_ev_valid = w_valid[i];
                w_ev_page  = w_page[i];
            end
        end
    end

    // Saturating fault counter; end of string zeroes it after the beat.
    assign w_faults_inc = (w_hit || (r_faults == '1)) ? r_faults : r_faults + COUNT_W'(1);

    always_comb begin
        n_faults = r_faults;
        if (w_accept) begin
            n_faults = i_in_data.end_of_string ? '0 : w_faults_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_faults <= '0;
        end else begin
            r_faults <= n_faults;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.hit           <= w_hit;
            r_out.evicted_valid <= !w_hit && w_ev_valid;
            r_out.evicted_page  <= (!w_hit && w_ev_valid) ? PAGE_W'(w_ev_page) : '0;
            r_out.fault_count   <= w_faults_inc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/lru_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_chk
// Port-level checks for the LRU page replacement stack, bound to the top level.
// ----------------------------------------------------------------------------
module lru_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input lru_pkg::t_out_beat   o_out_data
);
    import lru_pkg::*;

    // No result beat is pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

    // A stalled result beat stays valid.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result beat changed while stalled");

    // A hit never evicts a page.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.hit && o_out_data.evicted_valid))
        else $error("eviction reported on a hit");

    // A fault always leaves a nonzero fault count.
    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.hit |-> o_out_data.fault_count != '0)
        else $error("fault reported with zero fault count");

endmodule

bind lru_page_replacement_unit lru_chk u_lru_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
